FILE: src/stp_pkg.sv
// Shared constants, types and the square-root step for the trapezoidal profile block.
// Used by stepper_trapezoid_profile; depends on nothing else.
`default_nettype none
package stp_pkg;

    localparam int FRAC_BITS = 8;
    localparam int STEP_W    = 24;
    localparam int FMAX_W    = 17;
    localparam int ACC_W     = 20;
    localparam int FREQ_W    = 25;
    localparam int PHASE_W   = 3;
    localparam int SQ_ITER   = 24 + FRAC_BITS;
    localparam int ROOT_W    = SQ_ITER;
    localparam int REM_W     = ROOT_W + 4;
    localparam int RAD_W     = 2 * SQ_ITER;
    localparam int NUM_W     = 2 * FMAX_W + 1;
    localparam int DIV_W     = ACC_W + 1;
    localparam int CNT_W     = 6;

    localparam logic [ROOT_W-1:0] ONE_HZ   = ROOT_W'(1) << FRAC_BITS;
    localparam logic [FREQ_W-1:0] FREQ_SAT = {FREQ_W{1'b1}};

    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ACCEL  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CRUISE = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DECEL  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DONE   = 3'd4;

    localparam logic [1:0] REG_TOTAL = 2'd0;
    localparam logic [1:0] REG_FMAX  = 2'd1;
    localparam logic [1:0] REG_ACC   = 2'd2;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    // One digit of the restoring integer square root.
    function automatic t_sq sq_step(input t_sq s, input logic [1:0] b);
        t_sq              r;
        logic [REM_W-1:0] rn;
        logic [REM_W-1:0] trial;
        rn    = {s.rem[REM_W-3:0], b};
        trial = {2'b00, s.root, 2'b01};
        if (rn >= trial) begin
            r.rem  = rn - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = rn;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/stepper_trapezoid_profile.sv
// Top level of the trapezoidal velocity profile: APB registers, profile setup
// sequencer and the per-transaction pipeline. Depends on stp_pkg.
`default_nettype none
// Each input transaction carries a step count and returns one result through the
// s0 and s1 stages, the 32 stages of the bit-per-stage square root and the output
// register; the pipeline takes a new transaction every cycle while i_ready does not
// stall the output. After reset and after every register write, a setup sequencer
// works out the ramp length (a division) and the triangular peak (a square root);
// o_ready stays low until it finishes, while register writes are still taken.
module stepper_trapezoid_profile (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [3:0]                     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [stp_pkg::STEP_W-1:0]     i_step_count,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [stp_pkg::PHASE_W-1:0]    o_phase,
    output logic      [stp_pkg::STEP_W-1:0]     o_remaining_steps,
    output logic      [stp_pkg::FREQ_W-1:0]     o_target_frequency,
    output logic      [stp_pkg::STEP_W-1:0]     o_ramp_steps,
    output logic                                o_is_triangular
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_PREP = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam int         NST     = stp_pkg::SQ_ITER;

    logic [stp_pkg::STEP_W-1:0] r_total;
    logic [stp_pkg::FMAX_W-1:0] r_fmax;
    logic [stp_pkg::ACC_W-1:0]  r_acc_rate;

    logic                         wr;
    logic [stp_pkg::FMAX_W-1:0]   fmax_e;
    logic [stp_pkg::ACC_W-1:0]    a_e;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign fmax_e = (r_fmax == '0) ? stp_pkg::FMAX_W'(1) : r_fmax;
    assign a_e    = (r_acc_rate == '0) ? stp_pkg::ACC_W'(1) : r_acc_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_fmax     <= stp_pkg::FMAX_W'(1);
            r_acc_rate <= stp_pkg::ACC_W'(1);
        end else if (wr) begin
            unique case (paddr[3:2])
                stp_pkg::REG_TOTAL: r_total    <= pwdata[stp_pkg::STEP_W-1:0];
                stp_pkg::REG_FMAX:  r_fmax     <= pwdata[stp_pkg::FMAX_W-1:0];
                stp_pkg::REG_ACC:   r_acc_rate <= pwdata[stp_pkg::ACC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            stp_pkg::REG_TOTAL: prdata = 32'(r_total);
            stp_pkg::REG_FMAX:  prdata = 32'(r_fmax);
            stp_pkg::REG_ACC:   prdata = 32'(r_acc_rate);
            default:            prdata = '0;
        endcase
    end

    // Profile setup sequencer.
    logic [2:0]                   r_state;
    logic [stp_pkg::CNT_W-1:0]    r_cnt;
    logic [stp_pkg::NUM_W-1:0]    r_num;
    logic [stp_pkg::DIV_W-1:0]    r_drem;
    logic [stp_pkg::DIV_W-1:0]    r_a2;
    logic [stp_pkg::STEP_W-1:0]   r_acc;
    logic [stp_pkg::STEP_W-1:0]   r_dec;
    logic                         r_tri;
    logic [stp_pkg::ROOT_W-1:0]   r_peak;
    logic [stp_pkg::RAD_W-1:0]    r_sx;
    stp_pkg::t_sq                 r_sq;

    logic [stp_pkg::DIV_W:0]      d_trial;
    logic                         tri_c;
    logic [stp_pkg::STEP_W-1:0]   half_total;
    logic [stp_pkg::STEP_W-1:0]   acc_c;
    stp_pkg::t_sq                 sq_n;

    assign d_trial    = {r_drem, r_num[stp_pkg::NUM_W-1]};
    assign half_total = r_total >> 1;
    assign tri_c      = {r_num, 1'b0} >= (stp_pkg::NUM_W + 1)'(r_total);
    assign acc_c      = tri_c ? half_total : r_num[stp_pkg::STEP_W-1:0];
    assign sq_n       = stp_pkg::sq_step(r_sq, r_sx[stp_pkg::RAD_W-1 -: 2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_MUL;
            r_cnt   <= '0;
        end else if (wr) begin
            r_state <= ST_MUL;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_MUL: begin
                    r_state <= ST_DIV;
                    r_cnt   <= '0;
                end
                ST_DIV: begin
                    if (r_cnt == stp_pkg::CNT_W'(stp_pkg::NUM_W - 1)) begin
                        r_state <= ST_PREP;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_PREP: begin
                    r_state <= ST_SQRT;
                    r_cnt   <= '0;
                end
                ST_SQRT: begin
                    if (r_cnt == stp_pkg::CNT_W'(stp_pkg::SQ_ITER - 1)) begin
                        r_state <= ST_IDLE;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_MUL: begin
                r_num  <= stp_pkg::NUM_W'(fmax_e * fmax_e) + stp_pkg::NUM_W'(a_e);
                r_a2   <= {a_e, 1'b0};
                r_drem <= '0;
            end
            ST_DIV: begin
                if (d_trial >= {1'b0, r_a2}) begin
                    r_drem <= stp_pkg::DIV_W'(d_trial - {1'b0, r_a2});
                    r_num  <= {r_num[stp_pkg::NUM_W-2:0], 1'b1};
                end else begin
                    r_drem <= d_trial[stp_pkg::DIV_W-1:0];
                    r_num  <= {r_num[stp_pkg::NUM_W-2:0], 1'b0};
                end
            end
            ST_PREP: begin
                r_tri <= tri_c;
                r_acc <= acc_c;
                r_dec <= tri_c ? (r_total - acc_c) : acc_c;
                r_sx  <= stp_pkg::RAD_W'(r_a2 * half_total) << (2 * stp_pkg::FRAC_BITS);
                r_sq  <= '0;
            end
            ST_SQRT: begin
                r_sq <= sq_n;
                r_sx <= r_sx << 2;
                if (r_cnt == stp_pkg::CNT_W'(stp_pkg::SQ_ITER - 1)) begin
                    if (r_tri && (sq_n.root >= stp_pkg::ONE_HZ)) begin
                        r_peak <= sq_n.root;
                    end else begin
                        r_peak <= stp_pkg::ROOT_W'(fmax_e) << stp_pkg::FRAC_BITS;
                    end
                end
            end
            default: ;
        endcase
    end

    // Per-transaction pipeline; every stage advances together on en.
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en && (r_state == ST_IDLE);

    logic                           r_s0_valid;
    logic [stp_pkg::PHASE_W-1:0]    r_s0_phase;
    logic [stp_pkg::STEP_W-1:0]     r_s0_rem;
    logic [stp_pkg::STEP_W:0]       r_s0_n;
    logic                           r_s1_valid;
    logic [stp_pkg::PHASE_W-1:0]    r_s1_phase;
    logic [stp_pkg::STEP_W-1:0]     r_s1_rem;
    logic [stp_pkg::RAD_W-1:0]      r_s1_x;

    logic                           r_q_valid [NST];
    logic [stp_pkg::PHASE_W-1:0]    r_q_phase [NST];
    logic [stp_pkg::STEP_W-1:0]     r_q_rem   [NST];
    logic [stp_pkg::RAD_W-1:0]      r_q_x     [NST];
    stp_pkg::t_sq                   r_q_s     [NST];

    logic                           ge;
    logic [stp_pkg::STEP_W-1:0]     rem_c;
    logic [stp_pkg::PHASE_W-1:0]    phase_c;
    logic [stp_pkg::STEP_W:0]       n_c;

    assign ge    = i_step_count >= r_total;
    assign rem_c = ge ? '0 : (r_total - i_step_count);

    always_comb begin
        n_c = '0;
        priority if (r_total == '0) begin
            phase_c = stp_pkg::PH_IDLE;
        end else if (ge) begin
            phase_c = stp_pkg::PH_DONE;
        end else if (i_step_count < r_acc) begin
            phase_c = stp_pkg::PH_ACCEL;
            n_c     = {1'b0, i_step_count} + 1'b1;
        end else if (i_step_count >= (r_total - r_dec)) begin
            phase_c = stp_pkg::PH_DECEL;
            n_c     = {1'b0, rem_c};
        end else begin
            phase_c = stp_pkg::PH_CRUISE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            for (int k = 0; k < NST; k++) begin
                r_q_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_s0_valid   <= i_valid && o_ready;
            r_s1_valid   <= r_s0_valid;
            r_q_valid[0] <= r_s1_valid;
            for (int k = 1; k < NST; k++) begin
                r_q_valid[k] <= r_q_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_phase <= phase_c;
            r_s0_rem   <= rem_c;
            r_s0_n     <= n_c;
            r_s1_phase <= r_s0_phase;
            r_s1_rem   <= r_s0_rem;
            r_s1_x     <= stp_pkg::RAD_W'(r_a2 * r_s0_n) << (2 * stp_pkg::FRAC_BITS);
            r_q_phase[0] <= r_s1_phase;
            r_q_rem[0]   <= r_s1_rem;
            r_q_x[0]     <= r_s1_x;
            r_q_s[0]     <= stp_pkg::sq_step('0, r_s1_x[stp_pkg::RAD_W-1 -: 2]);
            for (int k = 1; k < NST; k++) begin
                r_q_phase[k] <= r_q_phase[k-1];
                r_q_rem[k]   <= r_q_rem[k-1];
                r_q_x[k]     <= r_q_x[k-1];
                r_q_s[k]     <= stp_pkg::sq_step(r_q_s[k-1],
                                    r_q_x[k-1][stp_pkg::RAD_W-1-2*k -: 2]);
            end
        end
    end

    // Output register with ramp clamping and saturation.
    logic                           r_o_valid;
    logic [stp_pkg::PHASE_W-1:0]    r_o_phase;
    logic [stp_pkg::STEP_W-1:0]     r_o_rem;
    logic [stp_pkg::FREQ_W-1:0]     r_o_freq;
    logic [stp_pkg::ROOT_W-1:0]     root_l;
    logic [stp_pkg::ROOT_W-1:0]     f_c;
    logic [stp_pkg::FREQ_W-1:0]     fsat_c;
    logic [stp_pkg::PHASE_W-1:0]    ph_l;

    assign root_l = r_q_s[NST-1].root;
    assign ph_l   = r_q_phase[NST-1];

    always_comb begin
        if ((ph_l == stp_pkg::PH_ACCEL) || (ph_l == stp_pkg::PH_DECEL)) begin
            priority if (root_l < stp_pkg::ONE_HZ) begin
                f_c = stp_pkg::ONE_HZ;
            end else if (root_l > r_peak) begin
                f_c = r_peak;
            end else begin
                f_c = root_l;
            end
        end else if (ph_l == stp_pkg::PH_CRUISE) begin
            f_c = r_peak;
        end else begin
            f_c = '0;
        end
        fsat_c = (f_c > stp_pkg::ROOT_W'(stp_pkg::FREQ_SAT)) ? stp_pkg::FREQ_SAT
                                                             : f_c[stp_pkg::FREQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_q_valid[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_phase <= ph_l;
            r_o_rem   <= r_q_rem[NST-1];
            r_o_freq  <= fsat_c;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_phase            = r_o_phase;
    assign o_remaining_steps  = r_o_rem;
    assign o_target_frequency = r_o_freq;
    assign o_ramp_steps       = r_acc;
    assign o_is_triangular    = r_tri;

    a_setup_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("input accepted during profile setup");

    a_zero_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_phase == stp_pkg::PH_IDLE) || (o_phase == stp_pkg::PH_DONE)))
        |-> (o_target_frequency == '0))
        else $error("nonzero frequency when idle or complete");

    a_cruise_trap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_phase == stp_pkg::PH_CRUISE)) |-> !o_is_triangular)
        else $error("cruise phase in a triangular profile");

endmodule
`default_nettype wire
